### hw/rtl/quicksort_engine_unit_assert.svh
// Assertion macros shared by the quicksort engine RTL.
// Each macro expands to a labeled concurrent assertion, or to nothing
// when assertions are switched off for a build.
`ifndef QUICKSORT_ENGINE_UNIT_ASSERT_SVH
`define QUICKSORT_ENGINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define QSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define QSE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define QSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define QSE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hw/rtl/qse_pkg.sv
package qse_pkg;

    // Width of one stored element.
    localparam int DATA_W = 32;

    // Default capacity of the sorting chain.
    localparam int DEF_MAX_ITEMS = 64;

    typedef logic signed [DATA_W-1:0] word_t;

    // One input item.
    typedef struct packed {
        word_t value;
        logic  last_in;
    } in_item_t;

    // One result item.
    typedef struct packed {
        word_t sorted_value;
        logic  last_out;
        logic  overflowed;
    } out_item_t;

    // A value with its qualifier, as it travels between neighboring cells.
    typedef struct packed {
        logic  valid;
        word_t value;
    } link_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_DRAIN = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

endpackage

### hw/rtl/qse_cell.sv
module qse_cell
    import qse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  link_t feed,
    input  link_t right,
    output link_t held,
    output link_t pass
);

    logic  occ_reg;
    logic  occ_next;
    word_t val_reg;
    word_t val_next;
    logic  pv_reg;
    logic  pv_next;
    word_t pval_reg;
    word_t pval_next;

    // Keep the smaller of the stored and arriving values, hand the larger
    // to the right neighbor. While unloading, take the right neighbor's entry.
    always_comb
    begin
        occ_next  = occ_reg;
        val_next  = val_reg;
        pv_next   = 1'b0;
        pval_next = pval_reg;
        if (shift)
        begin
            occ_next = right.valid;
            val_next = right.value;
        end
        else if (feed.valid)
        begin
            if (!occ_reg)
            begin
                occ_next = 1'b1;
                val_next = feed.value;
            end
            else if (feed.value < val_reg)
            begin
                val_next  = feed.value;
                pv_next   = 1'b1;
                pval_next = val_reg;
            end
            else
            begin
                pv_next   = 1'b1;
                pval_next = feed.value;
            end
        end
    end

    // Occupancy and the hand-off qualifier are control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            pv_reg  <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            pv_reg  <= pv_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        pval_reg <= pval_next;
    end

    assign held = '{valid: occ_reg, value: val_reg};
    assign pass = '{valid: pv_reg, value: pval_reg};

endmodule

### hw/rtl/qse_ctrl.sv
`include "quicksort_engine_unit_assert.svh"

module qse_ctrl
    import qse_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_last,
    output logic      item_stall,
    output logic      insert,
    output logic      shift,
    input  link_t     head,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] drain_reg;
    logic [CNT_W-1:0] drain_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             rv_reg;
    logic             rv_next;
    out_item_t        res_reg;
    out_item_t        res_next;

    logic accept;
    logic room;
    logic out_adv;

    // Items are taken only while loading.
    assign item_stall = (state_reg != S_LOAD);
    assign accept     = item_valid && !item_stall;
    assign room       = (count_reg < CNT_MAX);
    assign insert     = accept && room;
    assign out_adv    = !rv_reg || !result_stall;
    assign shift      = (state_reg == S_EMIT) && out_adv && (count_reg != '0);

    // Load, settle and unload sequencing.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drain_next = drain_reg;
        ovf_next   = ovf_reg;
        rv_next    = rv_reg;
        res_next   = res_reg;
        if (out_adv)
        begin
            rv_next = 1'b0;
        end
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item_last)
                    begin
                        state_next = S_DRAIN;
                        drain_next = CNT_MAX;
                    end
                end
            end
            S_DRAIN:
            begin
                // Give the last inserted value time to ripple to its cell.
                drain_next = drain_reg - CNT_ONE;
                if (drain_reg == CNT_ONE)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (shift)
                begin
                    rv_next  = 1'b1;
                    res_next = '{sorted_value: head.value,
                                 last_out:     (count_reg == CNT_ONE),
                                 overflowed:   ovf_reg};
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                    begin
                        state_next = S_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drain_reg <= '0;
            ovf_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drain_reg <= drain_next;
            ovf_reg   <= ovf_next;
            rv_reg    <= rv_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    // The stored count never passes the chain length.
    `QSE_ASSERT(a_count_cap, clk, rst_n, count_reg <= CNT_MAX, "element count beyond capacity")
    // A dropped item is always remembered for the run.
    `QSE_ASSERT(a_drop_flag, clk, rst_n, (accept && !room) |=> ovf_reg, "dropped item not flagged")
    // Sending the final result empties the chain and reopens the load.
    `QSE_ASSERT(a_run_end, clk, rst_n, (shift && count_reg == CNT_ONE) |=> (state_reg == S_LOAD && count_reg == '0 && !ovf_reg), "run did not end cleanly")

endmodule

### hw/rtl/quicksort_engine_unit.sv
// Loading takes one item per cycle; no result of a load leaves before its last_in.
// After the item flagged last_in, the cell chain settles for the ripple time
// of a value through all cells of the insertion chain.
// Results then leave one per cycle while result_stall is low, smallest first,
// N results for N stored.
// Reset clears the controller, cell occupancy and the overflow flag.
`include "quicksort_engine_unit_assert.svh"

module quicksort_engine_unit
    import qse_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic  insert;
    logic  shift;
    link_t pass [0:MAX_ITEMS];
    link_t held [0:MAX_ITEMS];

    // Sequencing and output register.
    qse_ctrl #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_last    (item.last_in),
        .item_stall   (item_stall),
        .insert       (insert),
        .shift        (shift),
        .head         (held[0]),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // New values enter at the left end; the right end is always empty.
    assign pass[0]         = '{valid: insert, value: item.value};
    assign held[MAX_ITEMS] = '0;

    // The sorting chain: ascending from left to right once settled.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        qse_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .feed  (pass[i]),
            .right (held[i+1]),
            .held  (held[i]),
            .pass  (pass[i+1])
        );
    end

    // No value may ever be pushed off the right end of the chain.
    `QSE_ASSERT_NEVER(a_no_spill, clk, rst_n, pass[MAX_ITEMS].valid, "value lost off chain end")

endmodule

### dv/qse_checker.sv
`timescale 1ns / 100ps

// Scoreboard for the quicksort engine. It follows every accepted item into a
// private copy of the element store, sorts that copy when the load ends, and
// compares each accepted result with the oldest sorted value still owed.
module qse_checker
    import qse_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_stall,
    input  in_item_t  item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result,
    output int        fail_count,
    output int        pending_results
);

    // Predicted state of the block.
    word_t     loaded_values [MAX_ITEMS];
    int        loaded_count;
    logic      overflow_seen;
    int        range_lo [MAX_ITEMS];
    int        range_hi [MAX_ITEMS];
    int        range_depth;

    out_item_t sorted_results [$];
    int        mismatches;

    // Ranges shorter than two elements are never stacked.
    function automatic void push_range(int lo, int hi);
        if (lo < hi && range_depth < MAX_ITEMS)
        begin
            range_lo[range_depth] = lo;
            range_hi[range_depth] = hi;
            range_depth++;
        end
    endfunction

    function automatic void swap_values(int a, int b);
        word_t held;
        held = loaded_values[a];
        loaded_values[a] = loaded_values[b];
        loaded_values[b] = held;
    endfunction

    // Quicksort with a Lomuto split around the last element of each range.
    // The larger side goes on the stack first so the smaller one is next.
    task automatic sort_loaded_values();
        int    lo;
        int    hi;
        int    fill;
        int    k;
        word_t pivot;
        range_depth = 0;
        if (loaded_count < 2)
            return;
        push_range(0, loaded_count - 1);
        while (range_depth > 0)
        begin
            range_depth--;
            lo = range_lo[range_depth];
            hi = range_hi[range_depth];
            pivot = loaded_values[hi];
            fill = lo;
            for (k = lo; k < hi; k++)
            begin
                if (loaded_values[k] <= pivot)
                begin
                    swap_values(fill, k);
                    fill++;
                end
            end
            swap_values(fill, hi);
            if (fill - lo >= hi - fill)
            begin
                push_range(lo, fill - 1);
                push_range(fill + 1, hi);
            end
            else
            begin
                push_range(fill + 1, hi);
                push_range(lo, fill - 1);
            end
        end
    endtask

    // Store one element, or drop it once the store is full. The item that
    // ends the load releases the whole sorted store as expected results.
    task automatic load_element(in_item_t it);
        out_item_t owed;
        int        k;
        if (loaded_count < MAX_ITEMS)
        begin
            loaded_values[loaded_count] = it.value;
            loaded_count++;
        end
        else
        begin
            overflow_seen = 1'b1;
        end
        if (it.last_in)
        begin
            sort_loaded_values();
            for (k = 0; k < loaded_count; k++)
            begin
                owed.sorted_value = loaded_values[k];
                owed.last_out     = (k == loaded_count - 1);
                owed.overflowed   = overflow_seen;
                sorted_results.push_back(owed);
            end
            loaded_count  = 0;
            range_depth   = 0;
            overflow_seen = 1'b0;
        end
    endtask

    // Results are checked before the new item is applied, so a result that
    // arrives with nothing owed is never hidden by the same edge's load.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t owed;
        if (!rst_n)
        begin
            loaded_count  = 0;
            range_depth   = 0;
            overflow_seen = 1'b0;
            mismatches    = 0;
            sorted_results.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (sorted_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual value %0d last %0b overflow %0b",
                             $time, result.sorted_value, result.last_out, result.overflowed);
                    mismatches++;
                end
                else
                begin
                    owed = sorted_results.pop_front();
                    if (result.sorted_value !== owed.sorted_value ||
                        result.last_out !== owed.last_out ||
                        result.overflowed !== owed.overflowed)
                    begin
                        $display("%0t: result mismatch: expected value %0d last %0b overflow %0b, actual value %0d last %0b overflow %0b",
                                 $time, owed.sorted_value, owed.last_out, owed.overflowed,
                                 result.sorted_value, result.last_out, result.overflowed);
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
                load_element(item);
        end
        fail_count      <= mismatches;
        pending_results <= sorted_results.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import qse_pkg::*;

    localparam int    MAX_ITEMS  = DEF_MAX_ITEMS;
    localparam int    LONG_HOLD  = 400;
    localparam word_t WORD_MIN   = 32'sh8000_0000;
    localparam word_t WORD_MAX   = 32'sh7fff_ffff;

    // Shapes of random content inside one load.
    typedef enum int {
        PAT_RANDOM,
        PAT_ASCEND,
        PAT_DESCEND,
        PAT_FEW,
        PAT_EXTREME
    } pattern_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    in_item_t  item         = '0;
    logic      result_stall = 1'b0;
    logic      item_stall;
    logic      result_valid;
    out_item_t result;

    int        fail_count;
    int        pending_results;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      hold_req       = 1'b0;
    int        items_sent     = 0;

    quicksort_engine_unit #(.MAX_ITEMS(MAX_ITEMS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    qse_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #10 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req <= 1'b0;
            end
            result_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one item after an optional random gap and hold it until taken.
    task automatic send_value(word_t elem, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{value: elem, last_in: last};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // One complete load of len items, the last one flagged.
    task automatic send_run(int len, pattern_t pattern);
        word_t base;
        word_t elem;
        int    k;
        base = $urandom;
        for (k = 0; k < len; k++)
        begin
            case (pattern)
                PAT_ASCEND:  elem = base + k;
                PAT_DESCEND: elem = base - k;
                PAT_FEW:     elem = word_t'($urandom_range(6)) - 3;
                PAT_EXTREME:
                begin
                    case ($urandom_range(3))
                        0:       elem = WORD_MIN;
                        1:       elem = WORD_MAX;
                        2:       elem = '0;
                        default: elem = -1;
                    endcase
                end
                default:     elem = $urandom;
            endcase
            send_value(elem, k == len - 1);
        end
    endtask

    // Mostly short loads, now and then one near or beyond the store's capacity.
    task automatic send_random_runs(int target);
        int       len;
        pattern_t pattern;
        while (items_sent < target)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS - 4);
            else
                len = $urandom_range(16, 1);
            if ($urandom_range(1) == 0)
                pattern = PAT_RANDOM;
            else
                pattern = pattern_t'($urandom_range(PAT_EXTREME, PAT_ASCEND));
            send_run(len, pattern);
        end
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_results_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed loads: single elements at both extremes, a reversed pair,
        // mixed signs, all-equal values and an already sorted load.
        send_value(WORD_MIN, 1'b1);
        send_value(WORD_MAX, 1'b1);
        send_value(WORD_MAX, 1'b0);
        send_value(WORD_MIN, 1'b1);
        send_value('0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value(WORD_MAX, 1'b0);
        send_value(WORD_MIN, 1'b1);
        for (k = 0; k < 4; k++)
            send_value(7, k == 3);
        for (k = 0; k < 6; k++)
            send_value(word_t'(k) - 3, k == 5);
        wait_results_drained();

        // Sender idles often, receiver stalls even more.
        send_idle_pct  = 26;
        recv_stall_pct = 46;
        send_random_runs(90);
        wait_results_drained();

        // Roles swapped.
        send_idle_pct  = 46;
        recv_stall_pct = 26;
        send_random_runs(160);
        wait_results_drained();

        // Full rate. A long receiver hold-off backs the block up while the
        // next load, which overruns the store, keeps pushing at the input.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        send_run(20, PAT_RANDOM);
        send_run(MAX_ITEMS + 6, PAT_RANDOM);
        send_run(MAX_ITEMS, PAT_DESCEND);
        wait_results_drained();
        send_random_runs(330);
        wait_results_drained();

        // Allow for a late or stray result before the verdict.
        repeat (2 * MAX_ITEMS + 20) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
